### hw/rtl/ptt_pkg.sv
// ptt_pkg: shared types and codes for the periodic tick timer table
// opcodes, status codes, sequencer states and default sizes; no dependencies

package ptt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int ID_W            = 32;
    localparam int FIELD_W         = 32;
    localparam int OP_W            = 2;
    localparam int STATUS_W        = 3;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CANCEL,
        S_TICK,
        S_TICK_END
    } ptt_state_t;

endpackage

### hw/rtl/ptt_if.sv
// ptt_if: request and response channel interfaces with valid/ready handshake
// depends on ptt_pkg for field widths

interface ptt_req_if;
    logic                              valid;
    logic                              ready;
    logic [ptt_pkg::OP_W-1:0]          opcode;
    logic [ptt_pkg::FIELD_W-1:0]       interval_ms;
    logic [ptt_pkg::ID_W-1:0]          job_id;
    logic [ptt_pkg::FIELD_W-1:0]       delta_ms;

    modport source (output valid, output opcode, output interval_ms, output job_id,
                    output delta_ms, input ready);
    modport sink   (input valid, input opcode, input interval_ms, input job_id,
                    input delta_ms, output ready);
endinterface

interface ptt_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [ptt_pkg::STATUS_W-1:0]      status;
    logic [ptt_pkg::ID_W-1:0]          result_id;
    logic                              last;

    modport source (output valid, output status, output result_id, output last,
                    input ready);
    modport sink   (input valid, input status, input result_id, input last,
                    output ready);
endinterface

### hw/rtl/ptt_ram.sv
// ptt_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/periodic_tick_timer_table.sv
// periodic_tick_timer_table: a table of periodic timers held in one ram. An add writes its
// entry if the table has room and registers its answer when accepted. A cancel scans the
// occupied slots for the id, one slot per cycle. A tick walks every occupied slot in order of
// adding, one slot per cycle while the response side does not stall, through the single read
// port of the entry ram with the write-back of the previous slot overlapped. Fired ids leave
// one per transaction, the final one flagged last; a tick with nothing fired gives one
// none-fired response. One request is in work at a time; a finished response waits in an
// output register.
// depends on ptt_pkg, ptt_if and ptt_ram

module periodic_tick_timer_table #(
    parameter int TABLE_DEPTH = ptt_pkg::TABLE_DEPTH_DEF,
    parameter int TIME_WIDTH  = ptt_pkg::TIME_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ptt_req_if.sink      req,
    ptt_rsp_if.source    rsp
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int TW     = TIME_WIDTH;
    localparam int ID_W   = ptt_pkg::ID_W;
    localparam int WORD_W = 2 * TW + ID_W + 1;
    localparam int EL_LO  = TW;
    localparam int ID_LO  = 2 * TW;
    localparam int EN_BIT = 2 * TW + ID_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    ptt_pkg::ptt_state_t state_reg, state_next;

    logic [CNT_W-1:0]              count_reg, count_next;
    logic [ID_W-1:0]               next_id_reg, next_id_next;
    logic [CNT_W-1:0]              ptr_reg, ptr_next;
    logic                          pend_reg, pend_next;
    logic [IDX_W-1:0]              eval_idx_reg, eval_idx_next;
    logic                          held_v_reg, held_v_next;
    logic [ID_W-1:0]               held_id_reg, held_id_next;
    logic [ID_W-1:0]               job_id_reg, job_id_next;
    logic [TW-1:0]                 delta_reg, delta_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [ptt_pkg::STATUS_W-1:0]  rsp_status_reg, rsp_status_next;
    logic [ID_W-1:0]               rsp_id_reg, rsp_id_next;
    logic                          rsp_last_reg, rsp_last_next;

    logic                          wr_en;
    logic [IDX_W-1:0]              wr_addr;
    logic [WORD_W-1:0]             wr_data;
    logic                          rd_en;
    logic [IDX_W-1:0]              rd_addr;
    logic [WORD_W-1:0]             rd_data;

    logic                          out_free;
    logic                          accept;
    logic [63:0]                   interval_wide;
    logic [63:0]                   delta_wide;
    logic [TW-1:0]                 rd_interval;
    logic [TW-1:0]                 rd_elapsed;
    logic [ID_W-1:0]               rd_ident;
    logic                          rd_enabled;
    logic [TW:0]                   elapsed_sum;
    logic [TW-1:0]                 elapsed_sat;
    logic                          fire;
    logic                          tick_stall;
    logic                          match;
    logic                          scan_done;

    ptt_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free      = !rsp_valid_reg || rsp.ready;
    assign req.ready     = (state_reg == ptt_pkg::S_IDLE) && out_free;
    assign accept        = req.valid && req.ready;
    assign interval_wide = 64'(req.interval_ms);
    assign delta_wide    = 64'(req.delta_ms);

    assign rd_interval = rd_data[TW-1:0];
    assign rd_elapsed  = rd_data[EL_LO +: TW];
    assign rd_ident    = rd_data[ID_LO +: ID_W];
    assign rd_enabled  = rd_data[EN_BIT];

    // saturating add of the tick delta
    assign elapsed_sum = {1'b0, rd_elapsed} + {1'b0, delta_reg};
    assign elapsed_sat = elapsed_sum[TW] ? {TW{1'b1}} : elapsed_sum[TW-1:0];
    assign fire        = pend_reg && rd_enabled && (elapsed_sat >= rd_interval);
    assign tick_stall  = fire && held_v_reg && !out_free;
    assign match       = pend_reg && (rd_ident == job_id_reg);
    assign scan_done   = !pend_reg && (ptr_reg == count_reg);

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.result_id = rsp_id_reg;
    assign rsp.last      = rsp_last_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptt_pkg::S_IDLE:
            begin
                if (accept && req.opcode == ptt_pkg::OP_CANCEL)
                begin
                    state_next = ptt_pkg::S_CANCEL;
                end
                else if (accept && req.opcode == ptt_pkg::OP_TICK)
                begin
                    state_next = ptt_pkg::S_TICK;
                end
            end
            ptt_pkg::S_CANCEL:
            begin
                if ((match || scan_done) && out_free)
                begin
                    state_next = ptt_pkg::S_IDLE;
                end
            end
            ptt_pkg::S_TICK:
            begin
                if (scan_done)
                begin
                    state_next = ptt_pkg::S_TICK_END;
                end
            end
            ptt_pkg::S_TICK_END:
            begin
                if (out_free)
                begin
                    state_next = ptt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ptt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        ptr_next        = ptr_reg;
        pend_next       = pend_reg;
        eval_idx_next   = eval_idx_reg;
        held_v_next     = held_v_reg;
        held_id_next    = held_id_reg;
        job_id_next     = job_id_reg;
        delta_next      = delta_reg;
        rsp_valid_next  = rsp.ready ? 1'b0 : rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_id_next     = rsp_id_reg;
        rsp_last_next   = rsp_last_reg;
        wr_en           = 1'b0;
        wr_addr         = eval_idx_reg;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg[IDX_W-1:0];

        case (state_reg)
            ptt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (req.opcode)
                        ptt_pkg::OP_ADD:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_last_next  = 1'b1;
                            if (count_reg == DEPTH_CNT)
                            begin
                                rsp_status_next = ptt_pkg::ST_FULL;
                                rsp_id_next     = '0;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = count_reg[IDX_W-1:0];
                                wr_data         = {1'b1, next_id_reg, {TW{1'b0}},
                                                   interval_wide[TW-1:0]};
                                rsp_status_next = ptt_pkg::ST_OK;
                                rsp_id_next     = next_id_reg;
                                count_next      = count_reg + 1'b1;
                                next_id_next    = next_id_reg + 1'b1;
                            end
                        end
                        ptt_pkg::OP_CANCEL:
                        begin
                            job_id_next = req.job_id;
                            ptr_next    = '0;
                            pend_next   = 1'b0;
                        end
                        ptt_pkg::OP_TICK:
                        begin
                            delta_next  = delta_wide[TW-1:0];
                            ptr_next    = '0;
                            pend_next   = 1'b0;
                            held_v_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ptt_pkg::S_CANCEL:
            begin
                if (match)
                begin
                    if (out_free)
                    begin
                        wr_en           = 1'b1;
                        wr_data         = rd_data;
                        wr_data[EN_BIT] = 1'b0;
                        rsp_valid_next  = 1'b1;
                        rsp_status_next = ptt_pkg::ST_OK;
                        rsp_id_next     = job_id_reg;
                        rsp_last_next   = 1'b1;
                        pend_next       = 1'b0;
                    end
                end
                else if (scan_done)
                begin
                    if (out_free)
                    begin
                        rsp_valid_next  = 1'b1;
                        rsp_status_next = ptt_pkg::ST_NOT_FOUND;
                        rsp_id_next     = job_id_reg;
                        rsp_last_next   = 1'b1;
                    end
                end
                else if (ptr_reg < count_reg)
                begin
                    rd_en         = 1'b1;
                    ptr_next      = ptr_reg + 1'b1;
                    eval_idx_next = ptr_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ptt_pkg::S_TICK:
            begin
                if (!tick_stall)
                begin
                    if (pend_reg && rd_enabled)
                    begin
                        wr_en   = 1'b1;
                        wr_data = rd_data;
                        wr_data[EL_LO +: TW] = fire ? {TW{1'b0}} : elapsed_sat;
                    end
                    if (fire)
                    begin
                        // previous fired id is not the final one
                        if (held_v_reg)
                        begin
                            rsp_valid_next  = 1'b1;
                            rsp_status_next = ptt_pkg::ST_FIRED;
                            rsp_id_next     = held_id_reg;
                            rsp_last_next   = 1'b0;
                        end
                        held_v_next  = 1'b1;
                        held_id_next = rd_ident;
                    end
                    if (ptr_reg < count_reg)
                    begin
                        rd_en         = 1'b1;
                        ptr_next      = ptr_reg + 1'b1;
                        eval_idx_next = ptr_reg[IDX_W-1:0];
                        pend_next     = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
            end
            ptt_pkg::S_TICK_END:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = held_v_reg ? ptt_pkg::ST_FIRED : ptt_pkg::ST_NONE;
                    rsp_id_next     = held_v_reg ? held_id_reg : '0;
                    rsp_last_next   = 1'b1;
                    held_v_next     = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptt_pkg::S_IDLE;
            count_reg     <= '0;
            next_id_reg   <= ID_W'(1);
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            held_v_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            next_id_reg   <= next_id_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            held_v_reg    <= held_v_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg   <= eval_idx_next;
        held_id_reg    <= held_id_next;
        job_id_reg     <= job_id_next;
        delta_reg      <= delta_next;
        rsp_status_reg <= rsp_status_next;
        rsp_id_reg     <= rsp_id_next;
        rsp_last_reg   <= rsp_last_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count above table depth");

    a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write of the same entry in one cycle");

    a_read_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (ptr_reg < count_reg))
        else $error("read of an unoccupied entry");

    a_held_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        held_v_reg |-> (state_reg == ptt_pkg::S_TICK || state_reg == ptt_pkg::S_TICK_END))
        else $error("pending fired id outside a tick");

    a_id_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.opcode == ptt_pkg::OP_ADD && count_reg != DEPTH_CNT)
        |=> (next_id_reg == $past(next_id_reg) + 1'b1) && rsp_valid_reg)
        else $error("add did not advance the id counter");

endmodule
